/* rtl/frame_parser_xor_checksum_top_macros.svh */
// Assertion macros for the frame parser.
`ifndef FRAME_PARSER_XOR_CHECKSUM_TOP_MACROS_SVH
`define FRAME_PARSER_XOR_CHECKSUM_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FPXC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame parser assertion failed");

// Next-cycle implication.
`define FPXC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame parser assertion failed");

`else

`define FPXC_ASSERT_NOW(label, clk, rst, ante, cons)
`define FPXC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/fpxc_pkg.sv */
package fpxc_pkg;

   localparam logic [7:0] CH_U     = 8'h55;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam logic [7:0] HDR_XOR  = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       frame_end;
      logic       frame_good;
   } rsp_type;

endpackage

/* rtl/fpxc_parser.sv */
module fpxc_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   output fpxc_pkg::rsp_type result
);

   typedef enum logic [2:0] {
      ST_START   = 3'd0,
      ST_HDR_N   = 3'd1,
      ST_HDR_E   = 3'd2,
      ST_HDR_R   = 3'd3,
      ST_LENGTH  = 3'd4,
      ST_TOKEN   = 3'd5,
      ST_PAYLOAD = 3'd6
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] count_eff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      xor_in    = xor_ff;
      result    = '0;
      count_eff = (count_ff == 8'd0) ? 8'd255 : count_ff;
      unique case (state_ff)
         ST_HDR_N, ST_HDR_E, ST_HDR_R: begin
            if ((state_ff == ST_HDR_N && rx_byte == fpxc_pkg::CH_N) ||
                (state_ff == ST_HDR_E && rx_byte == fpxc_pkg::CH_E)) begin
               state_in = state_type'(state_ff + 3'd1);
            end else if (state_ff == ST_HDR_R && rx_byte == fpxc_pkg::CH_R) begin
               state_in = ST_LENGTH;
            end else if (rx_byte == fpxc_pkg::CH_U) begin
               state_in = ST_HDR_N;
               xor_in   = 8'd0;
            end else begin
               state_in = ST_START;
            end
         end
         ST_LENGTH: begin
            count_in = rx_byte;
            state_in = ST_TOKEN;
         end
         ST_TOKEN: begin
            if (rx_byte == fpxc_pkg::CH_COLON) begin
               xor_in   = fpxc_pkg::HDR_XOR ^ count_ff;
               state_in = ST_PAYLOAD;
            end else if (rx_byte == fpxc_pkg::CH_U) begin
               state_in = ST_HDR_N;
               xor_in   = 8'd0;
            end else begin
               state_in = ST_START;
            end
         end
         ST_PAYLOAD: begin
            if (count_eff > 8'd1) begin
               xor_in               = xor_ff ^ rx_byte;
               count_in             = count_eff - 8'd1;
               result.payload_valid = 1'b1;
               result.payload_byte  = rx_byte;
            end else begin
               count_in          = 8'd0;
               result.frame_end  = 1'b1;
               result.frame_good = (xor_ff == rx_byte);
               if (rx_byte == fpxc_pkg::CH_U) begin
                  state_in = ST_HDR_N;
                  xor_in   = 8'd0;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         default: begin
            if (rx_byte == fpxc_pkg::CH_U) begin
               state_in = ST_HDR_N;
               xor_in   = 8'd0;
            end else begin
               state_in = ST_START;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         count_ff <= 8'd0;
         xor_ff   <= 8'd0;
      end else if (step) begin
         state_ff <= state_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
      end
   end

endmodule

/* rtl/frame_parser_xor_checksum_top.sv */
// Length-prefixed frame parser with XOR checksum.
// Input channel (req_): one received byte per beat on req_rx_byte, qualified by
// req_valid; the block raises req_stall when it cannot take a beat.
// Result channel (rsp_): exactly one result beat per input beat, in order:
// rsp_payload_valid/rsp_payload_byte for payload bytes, rsp_frame_end and
// rsp_frame_good on the checksum byte that closes a frame, all zero otherwise.
// Frames: 'U' 'N' 'E' 'R', length n, ':', n-1 payload bytes (254 if n is 0), checksum byte.
// Output: each result is registered in the output stage when its byte is accepted.
// Throughput: one byte per cycle while req_stall is low; the parser state updates on each accepted byte.
// Stall: a two-entry output stage holds results; req_stall rises only once
// both entries are full, so input can still be accepted after rsp_stall rises.
// Reset: synchronous, active high; the parser returns to hunting for 'U' and
// all buffered results are dropped.
`include "frame_parser_xor_checksum_top_macros.svh"

module frame_parser_xor_checksum_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_payload_valid,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_frame_end,
   output logic       rsp_frame_good
);

   fpxc_pkg::rsp_type result;
   fpxc_pkg::rsp_type out_ff;
   fpxc_pkg::rsp_type skid_ff;
   logic              out_valid_ff;
   logic              skid_valid_ff;
   logic              accept;
   logic              take;

   assign accept = req_valid && !skid_valid_ff;
   assign take   = out_valid_ff && !rsp_stall;

   fpxc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (accept),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept && out_valid_ff && !take) begin
         skid_valid_ff <= 1'b1;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (accept && out_valid_ff && !take) begin
         skid_ff <= result;
      end else if (accept) begin
         out_ff <= result;
      end
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = out_ff.payload_valid;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_frame_end     = out_ff.frame_end;
   assign rsp_frame_good    = out_ff.frame_good;

   `FPXC_ASSERT_NOW(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   `FPXC_ASSERT_NOW(a_kind_exclusive, clock, reset, out_valid_ff,
                    !(out_ff.payload_valid && out_ff.frame_end))
   `FPXC_ASSERT_NOW(a_good_needs_end, clock, reset, out_valid_ff && out_ff.frame_good,
                    out_ff.frame_end)
   `FPXC_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !rsp_stall,
                     !skid_valid_ff && out_valid_ff)

endmodule
